### rtl/core/text_console_writer_top_macros.svh
// assertion macros for the text console writer rtl
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// same-cycle implication, checked on clk with arst_n as the disable
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// shared constants and types for the text console writer
package tcw_pkg;

	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	localparam int CHAR_W    = 8;
	localparam int ROW_IN_W  = 5;
	localparam int COL_IN_W  = 7;
	localparam int POS_OUT_W = 11;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;
	localparam int M_PAD_W  = M_DATA_W - POS_OUT_W - CHAR_W;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0]    read_char;
		logic [POS_OUT_W-1:0] cursor_pos;
	} res_t;

endpackage

### rtl/core/tcw_ram.sv
// generic simple dual-port ram with registered read
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/tcw_seq.sv
// sequencer: cursor, scroll base, and writes and reads of the screen memory
`include "text_console_writer_top_macros.svh"

module tcw_seq #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               in_req,
	input  logic [tcw_pkg::CHAR_W-1:0]         in_char,
	input  logic [tcw_pkg::ROW_IN_W-1:0]       in_row,
	input  logic [tcw_pkg::COL_IN_W-1:0]       in_col,
	output logic                               res_valid,
	input  logic                               res_ready,
	output tcw_pkg::res_t                      res,
	output logic                               ram_we,
	output logic [$clog2(ROWS*COLS)-1:0]       ram_waddr,
	output logic [tcw_pkg::CHAR_W-1:0]         ram_wdata,
	output logic [$clog2(ROWS*COLS)-1:0]       ram_raddr,
	input  logic [tcw_pkg::CHAR_W-1:0]         ram_rdata
);

	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLS);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SCROLL,
		S_PUT,
		S_BS,
		S_RD_LIN,
		S_RD_ADDR,
		S_RD_DATA,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [POS_W-1:0]      pos_q;
	logic [COL_W-1:0]      col_q;
	logic [ADDR_W-1:0]     base_q;
	logic [COL_W-1:0]      scr_cnt_q;
	logic                  fill_q;
	logic [CHAR_W-1:0]     wch_q;
	logic [ROW_IN_W-1:0]   row_q;
	logic [COL_IN_W-1:0]   rcol_q;
	logic [ADDR_W-1:0]     lin_q;
	logic [CHAR_W-1:0]     rchar_q;

	logic                  at_end;
	logic                  rd_ok;
	logic [ADDR_W:0]       cur_sum;
	logic [ADDR_W-1:0]     cur_addr;
	logic [ADDR_W:0]       rd_sum;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     scr_addr;

	assign at_end = (pos_q == POS_W'(CELLS));
	assign rd_ok  = (32'(row_q) < ROWS) && (32'(rcol_q) < COLS);

	// screen is a ring of rows: physical address is logical plus base, mod cells
	assign cur_sum  = (ADDR_W+1)'(pos_q) + (ADDR_W+1)'(base_q);
	assign cur_addr = (cur_sum >= (ADDR_W+1)'(CELLS)) ?
		ADDR_W'(cur_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(cur_sum);
	assign rd_sum   = (ADDR_W+1)'(lin_q) + (ADDR_W+1)'(base_q);
	assign rd_addr  = (rd_sum >= (ADDR_W+1)'(CELLS)) ?
		ADDR_W'(rd_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(rd_sum);
	// the oldest row, at the scroll base, never wraps while it is blanked
	assign scr_addr = base_q + ADDR_W'(scr_cnt_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = CH_BLANK;
		ram_raddr = rd_addr;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_SCROLL: begin
				ram_we    = 1'b1;
				ram_waddr = scr_addr;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = wch_q;
			end
			S_BS: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			pos_q     <= '0;
			col_q     <= '0;
			base_q    <= '0;
			scr_cnt_q <= '0;
			fill_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						rchar_q   <= '0;
						row_q     <= in_row;
						rcol_q    <= in_col;
						scr_cnt_q <= '0;
						if (in_req == REQ_READ) begin
							state_q <= S_RD_LIN;
						end else begin
							unique case (in_char)
								CH_NEWLINE: begin
									fill_q  <= 1'b1;
									wch_q   <= CH_BLANK;
									state_q <= at_end ? S_SCROLL : S_PUT;
								end
								CH_BACKSPACE: begin
									if (pos_q != '0) begin
										pos_q   <= pos_q - 1'b1;
										col_q   <= (col_q == '0) ?
											COL_W'(COLS - 1) : col_q - 1'b1;
										state_q <= S_BS;
									end else begin
										state_q <= S_DONE;
									end
								end
								default: begin
									fill_q  <= 1'b0;
									wch_q   <= in_char;
									state_q <= at_end ? S_SCROLL : S_PUT;
								end
							endcase
						end
					end
				end
				S_SCROLL: begin
					scr_cnt_q <= scr_cnt_q + 1'b1;
					if (scr_cnt_q == COL_W'(COLS - 1)) begin
						base_q  <= (base_q == ADDR_W'(CELLS - COLS)) ?
							'0 : base_q + ADDR_W'(COLS);
						pos_q   <= POS_W'(CELLS - COLS);
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					pos_q <= pos_q + 1'b1;
					if (col_q == COL_W'(COLS - 1)) begin
						col_q   <= '0;
						state_q <= S_DONE;
					end else begin
						col_q <= col_q + 1'b1;
						// newline keeps padding until the row boundary
						if (!fill_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_BS: begin
					state_q <= S_DONE;
				end
				S_RD_LIN: begin
					if (rd_ok) begin
						lin_q   <= ADDR_W'(row_q * COLS) + ADDR_W'(rcol_q);
						state_q <= S_RD_ADDR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					rchar_q <= ram_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign res_valid      = (state_q == S_DONE);
	assign res.cursor_pos = POS_OUT_W'(pos_q);
	assign res.read_char  = rchar_q;

	`TCW_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= POS_W'(CELLS), "cursor past end of screen")
	`TCW_ASSERT_IMP(a_base_range, 1'b1, base_q <= ADDR_W'(CELLS - COLS), "scroll base out of range")
	`TCW_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`TCW_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res),
		"pending result changed")

endmodule

### rtl/core/text_console_writer_top.sv
// Text console writer, a ROWS x COLS character screen kept in one memory.
//
// Input stream (s_*): one transfer per request. s_tuser selects the kind:
// put a character at the cursor, or read the cell at read_row/read_col.
// Output stream (m_*): exactly one transfer per request, in order, carrying
// the cursor position after the request and, for reads, the character.
//
// Flow: an ordinary character and a backspace each write one cell before the
// result goes to the output register; a backspace at cursor zero writes nothing,
// and a read outside the screen skips the memory read. A newline writes one
// space per cycle up to the row boundary. A character stored at the end of the
// screen first blanks the oldest row through the single write port of the screen
// memory. Rows form a ring, so a scroll moves no data.
// Reset: the cursor goes to zero and the memory is filled with spaces at
// one cell per cycle, all ROWS*COLS cells (2000 by default), with s_tready low.
// Stall: a result waits in the output register while m_tready is low; the
// next request is then taken and worked on, and its result waits inside.
module text_console_writer_top #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code[7:0], read_row[12:8], read_col[19:13], zero[23:20]
	input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cursor_pos[10:0], read_char[18:11], zero[23:19]
	output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);

	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);

	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [CHAR_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [CHAR_W-1:0]   ram_rdata;
	logic                m_tvalid_q;
	res_t                m_res_q;

	tcw_seq #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_char   (s_tdata[7:0]),
		.in_row    (s_tdata[12:8]),
		.in_col    (s_tdata[19:13]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcw_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register frees the sequencer while the sink stalls
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_q.read_char, m_res_q.cursor_pos};

endmodule

### bench/text_console_writer_top_tb.sv
// self-checking stream bench for the text console writer: console prediction and random traffic
module text_console_writer_top_tb;
	import tcw_pkg::*;

	localparam int ROWS = ROWS_DEF;
	localparam int COLS = COLS_DEF;
	localparam int CELLS = ROWS * COLS;
	localparam int RANDOM_PER_PHASE = 160;
	localparam int DRAIN_CYCLES = 2 * COLS + 40;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic                req;
		logic [CHAR_W-1:0]   ch;
		logic [ROW_IN_W-1:0] row;
		logic [COL_IN_W-1:0] col;
	} console_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	console_req_t pending_reqs[$];
	console_req_t req_on_bus;
	res_t         expected_results[$];

	logic [CHAR_W-1:0] screen_model [0:CELLS-1];
	int unsigned       cursor_model;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;

	text_console_writer_top #(
		.ROWS(ROWS),
		.COLS(COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// scroll first when the cursor sits past the last cell
	function automatic void store_cell(logic [CHAR_W-1:0] c);
		if (cursor_model >= CELLS) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_model[i] = screen_model[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_model[i] = CH_BLANK;
			cursor_model = CELLS - COLS;
		end
		screen_model[cursor_model] = c;
		cursor_model++;
	endfunction

	function automatic res_t console_step(console_req_t r);
		res_t res;
		res = '0;
		if (r.req == REQ_READ) begin
			if (r.row < ROWS && r.col < COLS)
				res.read_char = screen_model[r.row * COLS + r.col];
		end else if (r.ch == CH_NEWLINE) begin
			store_cell(CH_BLANK);
			while (cursor_model % COLS != 0)
				store_cell(CH_BLANK);
		end else if (r.ch == CH_BACKSPACE) begin
			if (cursor_model > 0) begin
				cursor_model--;
				screen_model[cursor_model] = CH_BLANK;
			end
		end else begin
			store_cell(r.ch);
		end
		res.cursor_pos = cursor_model[POS_OUT_W-1:0];
		return res;
	endfunction

	function automatic console_req_t mk_req(logic req, int ch, int row, int col);
		console_req_t r;
		r.req = req;
		r.ch = ch[CHAR_W-1:0];
		r.row = row[ROW_IN_W-1:0];
		r.col = col[COL_IN_W-1:0];
		return r;
	endfunction

	// mostly puts, with frequent line breaks so the screen fills and scrolls
	function automatic console_req_t random_req();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			if ($urandom_range(0, 9) != 0)
				return mk_req(REQ_READ, $urandom_range(0, 255), $urandom_range(0, ROWS - 1),
					$urandom_range(0, COLS - 1));
			return mk_req(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 31),
				$urandom_range(0, 127));
		end
		if (pick < 55)
			return mk_req(REQ_PUT, CH_NEWLINE, $urandom_range(0, 31), $urandom_range(0, 127));
		if (pick < 65)
			return mk_req(REQ_PUT, CH_BACKSPACE, $urandom_range(0, 31), $urandom_range(0, 127));
		return mk_req(REQ_PUT, $urandom_range(0, 255), $urandom_range(0, 31),
			$urandom_range(0, 127));
	endfunction

	// driver: predict on each accepted transfer, then offer the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(console_step(req_on_bus));
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= req_on_bus.req;
					s_tdata <= {4'b0, req_on_bus.col, req_on_bus.row, req_on_bus.ch};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t got, exp_res;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[POS_OUT_W+CHAR_W-1:0];
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result cursor_pos=%0d read_char=%02h", $time,
						got.cursor_pos, got.read_char);
				end else begin
					exp_res = expected_results.pop_front();
					if (got.cursor_pos !== exp_res.cursor_pos) begin
						error_count++;
						$display("%0t: cursor_pos expected %0d actual %0d", $time,
							exp_res.cursor_pos, got.cursor_pos);
					end
					if (got.read_char !== exp_res.read_char) begin
						error_count++;
						$display("%0t: read_char expected %02h actual %02h", $time,
							exp_res.read_char, got.read_char);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = CH_BLANK;
		cursor_model = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (ph == 0) begin
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, 0, 0));
				pending_reqs.push_back(mk_req(REQ_PUT, CH_BACKSPACE, 0, 0));  // nothing to erase
				pending_reqs.push_back(mk_req(REQ_PUT, 8'h41, 31, 127));
				pending_reqs.push_back(mk_req(REQ_PUT, 8'h00, 0, 0));
				pending_reqs.push_back(mk_req(REQ_PUT, 8'hFF, 0, 0));
				pending_reqs.push_back(mk_req(REQ_READ, CH_NEWLINE, 0, 0));
				pending_reqs.push_back(mk_req(REQ_READ, 8'hFF, 0, 2));
				pending_reqs.push_back(mk_req(REQ_PUT, CH_BACKSPACE, 0, 0));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, 0, 2));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, 0, 1));
				pending_reqs.push_back(mk_req(REQ_PUT, CH_NEWLINE, 0, 0));
				pending_reqs.push_back(mk_req(REQ_PUT, 8'h42, 0, 0));
				pending_reqs.push_back(mk_req(REQ_PUT, CH_NEWLINE, 0, 0));
				// newline right on a row boundary pads a whole row
				pending_reqs.push_back(mk_req(REQ_PUT, CH_NEWLINE, 0, 0));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, 1, 0));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, ROWS - 1, COLS - 1));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, ROWS, 0));
				pending_reqs.push_back(mk_req(REQ_READ, 8'h00, 0, COLS));
				pending_reqs.push_back(mk_req(REQ_READ, 8'hFF, 31, 127));
				pending_reqs.push_back(mk_req(REQ_PUT, 8'h7F, 0, 0));
			end
			repeat (RANDOM_PER_PHASE) pending_reqs.push_back(random_req());
			// hold off until the block has answered everything
			while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_seq.sv
rtl/core/text_console_writer_top.sv
bench/text_console_writer_top_tb.sv
